>>> rtl/stepped_gain_agc_controller_assert.svh
// Assertion macros used by the checker of the stepped-gain AGC controller.
`ifndef STEPPED_GAIN_AGC_CONTROLLER_ASSERT_SVH
`define STEPPED_GAIN_AGC_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SGAGC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgagc assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define SGAGC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgagc assertion failed");

`endif

>>> rtl/sgagc_pkg.sv
// Types, register indexes and helper functions of the stepped-gain AGC controller.
package sgagc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_HIGH_THR  = 3'd0;
    localparam logic [2:0] REG_LOW_THR   = 3'd1;
    localparam logic [2:0] REG_SETTLE    = 3'd2;
    localparam logic [2:0] REG_HOLDOFF   = 3'd3;
    localparam logic [2:0] REG_PHASE     = 3'd4;
    localparam logic [2:0] REG_INIT_LINE = 3'd5;

    // Gain limits and the largest settle counter value.
    localparam logic [2:0]  GAIN_MAX = 3'd4;
    localparam logic [17:0] CNT_MAX  = 18'h1FFFF;

    typedef struct packed {
        logic [15:0] high_threshold;
        logic [15:0] low_threshold;
        logic [15:0] settle_count;
        logic [15:0] holdoff_ticks;
        logic [3:0]  second_phase;
        logic [3:0]  initial_lines;
    } cfg_t;

    typedef struct packed {
        logic [15:0] range_level;
        logic [5:0]  second_now;
        logic        holdoff_request;
    } item_t;

    typedef struct packed {
        logic [2:0] gain;
        logic       adjusted;
    } agc_res_t;

    // Second of the minute reduced modulo ten with three compare-subtract steps.
    function automatic logic [3:0] sec_mod10(input logic [5:0] sec);
        logic [5:0] r;
        r = sec;
        if (r >= 6'd40) r = r - 6'd40;
        if (r >= 6'd20) r = r - 6'd20;
        if (r >= 6'd10) r = r - 6'd10;
        return r[3:0];
    endfunction

    // The lowest zero line bit picks the starting gain; all ones keeps it.
    function automatic logic [2:0] initial_gain(input logic [3:0] lines,
                                                input logic [2:0] current);
        logic [2:0] g;
        if (!lines[0])      g = 3'd4;
        else if (!lines[1]) g = 3'd3;
        else if (!lines[2]) g = 3'd2;
        else if (!lines[3]) g = 3'd1;
        else                g = current;
        return g;
    endfunction

endpackage

>>> rtl/sgagc_core.sv
// Gain state, settle counter and the per-tick adjustment decision.
module sgagc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  sgagc_pkg::item_t  item,
    input  sgagc_pkg::cfg_t   cfg,
    output sgagc_pkg::agc_res_t res
);
    import sgagc_pkg::*;

    logic [2:0]  gain_reg, gain_next;
    logic [17:0] cnt_reg, cnt_next;
    logic        first_reg;

    logic [2:0]  gain_start;
    logic [17:0] cnt_load;
    logic [17:0] cnt_inc;
    logic [14:0] half;
    logic        settle_ok;
    logic        phase_ok;
    logic        adjust;

    // Start gain: taken from the line bits on the first tick only.
    assign gain_start = first_reg ? initial_gain(cfg.initial_lines, gain_reg) : gain_reg;

    // Hold-off load, then a saturating increment.
    assign cnt_load = item.holdoff_request ? (18'd0 - {2'b00, cfg.holdoff_ticks}) : cnt_reg;
    assign cnt_inc  = (cnt_load != CNT_MAX) ? cnt_load + 18'd1 : cnt_load;

    // Both gates must pass before the gain moves.
    assign settle_ok = $signed(cnt_inc) >= $signed({2'b00, cfg.settle_count});
    assign phase_ok  = sec_mod10(item.second_now) == cfg.second_phase;
    assign adjust    = settle_ok && phase_ok;
    assign half      = item.range_level[15:1];

    // Step down wins when both thresholds are crossed; limits hold the gain.
    always_comb
    begin
        gain_next = gain_start;
        cnt_next  = cnt_inc;
        if (adjust)
        begin
            cnt_next = '0;
            if ({1'b0, half} > cfg.high_threshold)
            begin
                if (gain_start != 3'd0) gain_next = gain_start - 3'd1;
            end
            else if ({1'b0, half} < cfg.low_threshold)
            begin
                if (gain_start < GAIN_MAX) gain_next = gain_start + 3'd1;
            end
        end
    end

    assign res.gain     = gain_next;
    assign res.adjusted = adjust;

    // State advances once per tick that leaves the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= '0;
            cnt_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (fire)
        begin
            gain_reg  <= gain_next;
            cnt_reg   <= cnt_next;
            first_reg <= 1'b0;
        end
    end

endmodule

>>> rtl/stepped_gain_agc_controller.sv
// Stepped-gain AGC controller: one tick in, one result out, one tick per clock cycle while
// out_ready is high. Each tick passes an input register and then the result register, and a
// new tick can be taken every cycle while out_ready is high; the throughput is set by the
// single gain-and-counter update done per tick between those two registers. Configuration
// is written through cfg_valid/cfg_index/cfg_data, which is always ready; it must only be
// changed while no tick is in flight.
module stepped_gain_agc_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] range_level,
    input  logic [5:0]  second_now,
    input  logic        holdoff_request,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  gain_step,
    output logic        line_one,
    output logic        line_two,
    output logic        line_three,
    output logic        line_four,
    output logic        adjusted,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sgagc_pkg::*;

    cfg_t     cfg_reg;
    item_t    item_reg;
    logic     s1_valid_reg;
    logic     out_valid_reg;
    agc_res_t res_reg;
    agc_res_t res_next;
    logic     s1_take;

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_threshold <= 16'd2000;
            cfg_reg.low_threshold  <= 16'd1000;
            cfg_reg.settle_count   <= 16'd10000;
            cfg_reg.holdoff_ticks  <= 16'd59000;
            cfg_reg.second_phase   <= 4'd3;
            cfg_reg.initial_lines  <= 4'd15;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HIGH_THR:  cfg_reg.high_threshold <= cfg_data;
                REG_LOW_THR:   cfg_reg.low_threshold  <= cfg_data;
                REG_SETTLE:    cfg_reg.settle_count   <= cfg_data;
                REG_HOLDOFF:   cfg_reg.holdoff_ticks  <= cfg_data;
                REG_PHASE:     cfg_reg.second_phase   <= cfg_data[3:0];
                REG_INIT_LINE: cfg_reg.initial_lines  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Pipeline control: the input stage moves on when the result register is free.
    assign s1_take  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready) s1_valid_reg <= in_valid;
            if (s1_take) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.range_level     <= range_level;
            item_reg.second_now      <= second_now;
            item_reg.holdoff_request <= holdoff_request;
        end
    end

    sgagc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_take),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (res_next)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (s1_take) res_reg <= res_next;
    end

    // Thermometer-coded control lines follow the reported gain.
    assign out_valid  = out_valid_reg;
    assign gain_step  = res_reg.gain;
    assign adjusted   = res_reg.adjusted;
    assign line_one   = res_reg.gain <= 3'd3;
    assign line_two   = res_reg.gain <= 3'd2;
    assign line_three = res_reg.gain <= 3'd1;
    assign line_four  = res_reg.gain == 3'd0;

endmodule

>>> rtl/sgagc_checker.sv
// Port-level checker of the stepped-gain AGC controller and its bind.
`include "stepped_gain_agc_controller_assert.svh"

module sgagc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] gain_step,
    input logic       line_one,
    input logic       line_two,
    input logic       line_three,
    input logic       line_four
);

    logic [3:0] lines_exp;

    // Thermometer code expected for the reported gain.
    assign lines_exp = {gain_step <= 3'd3, gain_step <= 3'd2, gain_step <= 3'd1,
                        gain_step == 3'd0};

    // A result that is not taken stays offered.
    `SGAGC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

    // The gain never leaves its range.
    `SGAGC_ASSERT_IMP(a_gain_range, out_valid, gain_step <= 3'd4)

    // The lines always form the thermometer code of the reported gain.
    `SGAGC_ASSERT_IMP(a_lines, out_valid, {line_one, line_two, line_three, line_four} == lines_exp)

endmodule

bind stepped_gain_agc_controller sgagc_checker u_sgagc_checker (.*);
